// ----- rtl/bsq_pkg.sv -----
// billboard sprite quad: shared types, register indexes and constants
// no dependencies; imported by the interface users and the top level
`timescale 1ns / 1ps
`default_nettype none

package bsq_pkg;

    localparam logic [2:0] CFG_HALF_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_HEIGHT       = 3'd1;
    localparam logic [2:0] CFG_FRAME_PERIOD = 3'd2;
    localparam logic [2:0] CFG_COLUMNS      = 3'd3;
    localparam logic [2:0] CFG_ROWS         = 3'd4;
    localparam logic [2:0] CFG_ANIMATED     = 3'd5;
    localparam logic [2:0] CFG_LOOP         = 3'd6;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [15:0] ONE_UV  = 16'h8000;

    typedef struct packed {
        logic               start_req;
        logic [19:0]        time_delta_us;
        logic               camera_valid;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         corner_index;
        logic signed [31:0] corner_x;
        logic signed [31:0] corner_y;
        logic signed [31:0] corner_z;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [8:0]         frame_number;
        logic               last_corner;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [30:0] value;
    } t_cfg_wr;

    function automatic logic [15:0] f_mag16(input logic signed [15:0] x);
        return x[15] ? 16'(-x) : 16'(x);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bsq_chan_if.sv -----
// valid/ready channel carrying one payload per transaction
// payload type is set per instance (bsq_pkg structs)
`timescale 1ns / 1ps
`default_nettype none

interface bsq_chan_if #(parameter type t_data = logic);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bsq_isqrt.sv -----
// floor square root of a 64-bit value, two radicand bits per cycle
// standalone; used by billboard_sprite_quad_unit
`timescale 1ns / 1ps
`default_nettype none

module bsq_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_value,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_v;
    logic [33:0] r_rem;
    logic [31:0] r_root;

    logic [35:0] sh;
    logic [35:0] trial;
    logic        ge;

    assign sh    = {r_rem, r_v[63:62]};
    assign trial = {2'b00, r_root, 2'b01};
    assign ge    = sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_v    <= {r_v[61:0], 2'b00};
                r_rem  <= ge ? 34'(sh - trial) : sh[33:0];
                r_root <= {r_root[30:0], ge};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ----- rtl/bsq_div.sv -----
// restoring divider, 62-bit dividend by 32-bit divisor, one quotient bit per cycle
// standalone; used by billboard_sprite_quad_unit
`timescale 1ns / 1ps
`default_nettype none

module bsq_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [61:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [61:0]      o_quot,
    output logic [31:0]      o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [61:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;

    logic [32:0] sh;
    logic        ge;

    assign sh = {r_rem, r_q[61]};
    assign ge = sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_q   <= {r_q[60:0], ge};
                r_rem <= ge ? 32'(sh - {1'b0, r_dvs}) : sh[31:0];
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd61) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ----- rtl/billboard_sprite_quad_unit.sv -----
// Camera-facing billboard with sprite-sheet animation. A tick without a camera
// delivers the stored corners. A tick with a camera runs a shared multiplier over the
// cross product and squares, two square roots, six divisions for normalizing (each
// skipped, giving zero, for a zero-length vector), six scale products, the corner sums
// and, when animated, five more divisions for the sheet cell; the divider is shared
// and yields one quotient bit per cycle.
// Depends on bsq_pkg, bsq_chan_if, bsq_isqrt and bsq_div.
`timescale 1ns / 1ps
`default_nettype none

module billboard_sprite_quad_unit #(
    parameter int MAX_SHEET_SIDE = 16,
    parameter int COORD_WIDTH    = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bsq_chan_if.sink   i_in,
    bsq_chan_if.source o_out,
    bsq_chan_if.sink   i_cfg
);

    import bsq_pkg::*;

    localparam int M2 = (MAX_SHEET_SIDE < 31) ? MAX_SHEET_SIDE : 31;
    localparam int FWC = $clog2(M2 * M2 + 2);
    localparam int FW = (FWC > 9) ? FWC : 9;
    localparam int SW = (COORD_WIDTH > 34) ? COORD_WIDTH + 1 : 35;
    localparam logic signed [SW-1:0] C_HI =
        {{(SW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] C_LO = ~C_HI;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAC, ST_SQR, ST_SQU, ST_DIV, ST_SCL, ST_CRN, ST_UV, ST_OUT
    } t_state;

    t_state r_state;
    logic [3:0] r_step;
    logic [4:0] r_pstep;
    logic r_pv, r_pneg, r_wait, r_sq_start, r_dv_start;
    logic r_active, r_emit;
    logic [FW-1:0] r_frame;
    logic [20:0] r_tacc;

    logic [30:0] r_hw, r_hs;
    logic [19:0] r_period;
    logic [4:0] r_cols, r_rows;
    logic r_anim, r_loop;

    logic signed [15:0] r_u [3];
    logic signed [15:0] r_d [3];
    logic signed [31:0] r_ctr [3];
    logic signed [33:0] r_acc;
    logic signed [33:0] r_cr [3];
    logic [63:0] r_sum, r_sumr, r_prod;
    logic [31:0] r_lenr, r_lenu;
    logic [30:0] r_n [6];
    logic [5:0] r_nneg;
    logic [30:0] r_off [6];
    logic [1:0] r_ci, r_ax, r_k;
    logic [31:0] r_cs [4][3];
    logic [15:0] r_tu0, r_tu1, r_tv0, r_tv1;
    logic [4:0] r_col0, r_row0;

    // sheet size and tick bookkeeping
    logic [4:0] cols_c, rows_c;
    logic [FW-1:0] total_c, fr_c, fr_n;
    logic [20:0] ta_c, ta_n;
    logic in_acc, act_c, deact_c;
    t_in_item in_d;

    assign in_d = i_in.data;
    assign in_acc = i_in.valid & i_in.ready;

    always_comb begin
        cols_c = (r_cols == 5'd0) ? 5'd1 :
                 (int'(r_cols) > MAX_SHEET_SIDE) ? 5'(MAX_SHEET_SIDE) : r_cols;
        rows_c = (r_rows == 5'd0) ? 5'd1 :
                 (int'(r_rows) > MAX_SHEET_SIDE) ? 5'(MAX_SHEET_SIDE) : r_rows;
        total_c = FW'(cols_c) * FW'(rows_c);
        act_c = in_d.start_req | r_active;
        fr_c = in_d.start_req ? FW'(1) : r_frame;
        ta_c = in_d.start_req ? 21'd0 : r_tacc;
        deact_c = r_anim & ~r_loop & (fr_c == total_c);
        fr_n = fr_c;
        ta_n = ta_c;
        if (r_anim) begin
            ta_n = ta_c + 21'(in_d.time_delta_us);
            if (ta_n > 21'(r_period)) begin
                fr_n = fr_c + FW'(1);
                ta_n = '0;
            end
            if (fr_n > total_c) begin
                fr_n = FW'(1);
                ta_n = '0;
            end
        end
    end

    // shared multiplier operand select
    logic [31:0] cr_mag [3];
    logic [31:0] mac_a, mac_b;
    logic mac_neg;
    logic [30:0] scl_n, scl_size;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cr_mag[i] = r_cr[i][33] ? 32'(-r_cr[i]) : 32'(r_cr[i]);
        end
    end

    always_comb begin
        scl_n = '0;
        scl_size = r_hw;
        case (r_step)
            4'd0: scl_n = r_n[0];
            4'd1: scl_n = r_n[1];
            4'd2: scl_n = r_n[2];
            4'd3: begin scl_n = r_n[3]; scl_size = r_hs; end
            4'd4: begin scl_n = r_n[4]; scl_size = r_hs; end
            4'd5: begin scl_n = r_n[5]; scl_size = r_hs; end
            default: scl_n = '0;
        endcase
    end

    always_comb begin
        mac_a = '0;
        mac_b = '0;
        mac_neg = 1'b0;
        if (r_state == ST_SCL) begin
            mac_a = {1'b0, scl_n};
            mac_b = {1'b0, scl_size};
        end else begin
            case (r_step)
                4'd0: begin
                    mac_a = 32'(f_mag16(r_u[1])); mac_b = 32'(f_mag16(r_d[2]));
                    mac_neg = r_u[1][15] ^ r_d[2][15];
                end
                4'd1: begin
                    mac_a = 32'(f_mag16(r_u[2])); mac_b = 32'(f_mag16(r_d[1]));
                    mac_neg = ~(r_u[2][15] ^ r_d[1][15]);
                end
                4'd2: begin
                    mac_a = 32'(f_mag16(r_u[2])); mac_b = 32'(f_mag16(r_d[0]));
                    mac_neg = r_u[2][15] ^ r_d[0][15];
                end
                4'd3: begin
                    mac_a = 32'(f_mag16(r_u[0])); mac_b = 32'(f_mag16(r_d[2]));
                    mac_neg = ~(r_u[0][15] ^ r_d[2][15]);
                end
                4'd4: begin
                    mac_a = 32'(f_mag16(r_u[0])); mac_b = 32'(f_mag16(r_d[1]));
                    mac_neg = r_u[0][15] ^ r_d[1][15];
                end
                4'd5: begin
                    mac_a = 32'(f_mag16(r_u[1])); mac_b = 32'(f_mag16(r_d[0]));
                    mac_neg = ~(r_u[1][15] ^ r_d[0][15]);
                end
                4'd6: begin mac_a = cr_mag[0]; mac_b = cr_mag[0]; end
                4'd7: begin mac_a = cr_mag[1]; mac_b = cr_mag[1]; end
                4'd8: begin mac_a = cr_mag[2]; mac_b = cr_mag[2]; end
                4'd9: begin
                    mac_a = 32'(f_mag16(r_u[0])); mac_b = 32'(f_mag16(r_u[0]));
                end
                4'd10: begin
                    mac_a = 32'(f_mag16(r_u[1])); mac_b = 32'(f_mag16(r_u[1]));
                end
                4'd11: begin
                    mac_a = 32'(f_mag16(r_u[2])); mac_b = 32'(f_mag16(r_u[2]));
                end
                default: mac_a = '0;
            endcase
        end
    end

    logic signed [33:0] sp;
    assign sp = r_pneg ? -$signed({2'b00, r_prod[31:0]}) : $signed({2'b00, r_prod[31:0]});

    // normalize division operands
    logic [31:0] div_c, div_len;
    logic div_neg;

    always_comb begin
        div_c = '0;
        div_len = r_lenr;
        div_neg = 1'b0;
        case (r_step)
            4'd0: begin div_c = cr_mag[0]; div_neg = r_cr[0][33]; end
            4'd1: begin div_c = cr_mag[1]; div_neg = r_cr[1][33]; end
            4'd2: begin div_c = cr_mag[2]; div_neg = r_cr[2][33]; end
            4'd3: begin
                div_c = 32'(f_mag16(r_u[0])); div_len = r_lenu; div_neg = r_u[0][15];
            end
            4'd4: begin
                div_c = 32'(f_mag16(r_u[1])); div_len = r_lenu; div_neg = r_u[1][15];
            end
            4'd5: begin
                div_c = 32'(f_mag16(r_u[2])); div_len = r_lenu; div_neg = r_u[2][15];
            end
            default: div_c = '0;
        endcase
    end

    logic [FW-1:0] f0;
    logic [61:0] dv_dividend;
    logic [31:0] dv_divisor;
    logic dv_done, sq_done;
    logic [61:0] dv_quot;
    logic [31:0] dv_rem, sq_root;
    logic [30:0] q_cap;
    logic [15:0] e_cap;

    assign f0 = r_frame - FW'(1);

    always_comb begin
        dv_dividend = {div_c, 30'd0};
        dv_divisor = div_len;
        if (r_state == ST_UV) begin
            dv_divisor = 32'(cols_c);
            case (r_step)
                4'd0: dv_dividend = 62'(f0);
                4'd1: dv_dividend = 62'({r_col0, 15'd0});
                4'd2: dv_dividend = 62'({6'(r_col0) + 6'd1, 15'd0});
                4'd3: begin
                    dv_dividend = 62'({r_row0, 15'd0}); dv_divisor = 32'(rows_c);
                end
                4'd4: begin
                    dv_dividend = 62'({6'(r_row0) + 6'd1, 15'd0});
                    dv_divisor = 32'(rows_c);
                end
                default: dv_dividend = '0;
            endcase
        end
    end

    assign q_cap = (dv_quot > 62'(ONE_Q30)) ? ONE_Q30 : dv_quot[30:0];
    assign e_cap = (dv_quot > 62'(ONE_UV)) ? ONE_UV : dv_quot[15:0];

    bsq_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_value ((r_state == ST_SQR) ? r_sumr : r_sum),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    bsq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dv_start),
        .i_dividend (dv_dividend),
        .i_divisor  (dv_divisor),
        .o_done     (dv_done),
        .o_quot     (dv_quot),
        .o_rem      (dv_rem)
    );

    // corner sum and saturation
    logic signed [SW-1:0] c_sum, c_sat, c_ro, c_uo;
    logic [2:0] ro_idx, uo_idx;

    always_comb begin
        ro_idx = {1'b0, r_ax};
        uo_idx = {1'b0, r_ax} + 3'd3;
        c_ro = SW'($signed({1'b0, r_off[ro_idx]}));
        c_uo = SW'($signed({1'b0, r_off[uo_idx]}));
        if (r_nneg[ro_idx] ^ ~r_ci[0]) c_ro = -c_ro;
        if (r_nneg[uo_idx] ^ ~r_ci[1]) c_uo = -c_uo;
        c_sum = SW'(r_ctr[r_ax]) + c_ro + c_uo;
        c_sat = (c_sum > C_HI) ? C_HI : ((c_sum < C_LO) ? C_LO : c_sum);
    end

    t_cfg_wr cfg_d;
    assign cfg_d = i_cfg.data;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step <= '0;
            r_pv <= 1'b0;
            r_wait <= 1'b0;
            r_sq_start <= 1'b0;
            r_dv_start <= 1'b0;
            r_active <= 1'b0;
            r_emit <= 1'b0;
            r_frame <= FW'(1);
            r_tacc <= '0;
            r_hw <= 31'd131072;
            r_hs <= 31'd131072;
            r_period <= 20'd50000;
            r_cols <= 5'd4;
            r_rows <= 5'd4;
            r_anim <= 1'b0;
            r_loop <= 1'b1;
            r_k <= '0;
            r_ci <= '0;
            r_ax <= '0;
            r_tu0 <= '0;
            r_tu1 <= '0;
            r_tv0 <= '0;
            r_tv1 <= '0;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 3; j++) r_cs[i][j] <= '0;
            end
        end else begin
            r_sq_start <= 1'b0;
            r_dv_start <= 1'b0;
            r_pv <= 1'b0;

            if (i_cfg.valid) begin
                case (cfg_d.index)
                    CFG_HALF_WIDTH:   r_hw <= cfg_d.value;
                    CFG_HEIGHT:       r_hs <= cfg_d.value;
                    CFG_FRAME_PERIOD: r_period <= cfg_d.value[19:0];
                    CFG_COLUMNS:      r_cols <= cfg_d.value[4:0];
                    CFG_ROWS:         r_rows <= cfg_d.value[4:0];
                    CFG_ANIMATED:     r_anim <= cfg_d.value[0];
                    CFG_LOOP:         r_loop <= cfg_d.value[0];
                    default:          r_loop <= r_loop;
                endcase
            end

            // multiplier writeback, one transaction behind the issue
            if (r_pv) begin
                case (r_pstep)
                    5'd0, 5'd2, 5'd4: r_acc <= sp;
                    5'd1: r_cr[0] <= r_acc + sp;
                    5'd3: r_cr[1] <= r_acc + sp;
                    5'd5: r_cr[2] <= r_acc + sp;
                    5'd6, 5'd9: r_sum <= r_prod;
                    5'd7, 5'd10, 5'd11: r_sum <= r_sum + r_prod;
                    5'd8: r_sumr <= r_sum + r_prod;
                    5'd16: r_off[0] <= r_prod[61:31];
                    5'd17: r_off[1] <= r_prod[61:31];
                    5'd18: r_off[2] <= r_prod[61:31];
                    5'd19: r_off[3] <= r_prod[61:31];
                    5'd20: r_off[4] <= r_prod[61:31];
                    5'd21: r_off[5] <= r_prod[61:31];
                    default: r_acc <= r_acc;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc && act_c) begin
                        r_frame <= fr_n;
                        r_tacc <= ta_n;
                        r_active <= ~deact_c;
                        r_emit <= ~deact_c;
                        r_u[0] <= in_d.up_x;
                        r_u[1] <= in_d.up_y;
                        r_u[2] <= in_d.up_z;
                        r_d[0] <= in_d.dir_x;
                        r_d[1] <= in_d.dir_y;
                        r_d[2] <= in_d.dir_z;
                        r_ctr[0] <= in_d.center_x;
                        r_ctr[1] <= in_d.center_y;
                        r_ctr[2] <= in_d.center_z;
                        r_step <= '0;
                        r_k <= '0;
                        if (in_d.camera_valid) r_state <= ST_MAC;
                        else if (!deact_c) r_state <= ST_OUT;
                    end
                end
                ST_MAC: begin
                    r_prod <= mac_a * mac_b;
                    r_pneg <= mac_neg;
                    r_pstep <= 5'(r_step);
                    r_pv <= (r_step != 4'd12);
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd12) r_state <= ST_SQR;
                end
                ST_SQR, ST_SQU: begin
                    if (!r_wait) begin
                        r_sq_start <= 1'b1;
                        r_wait <= 1'b1;
                    end else if (sq_done) begin
                        r_wait <= 1'b0;
                        if (r_state == ST_SQR) begin
                            r_lenr <= sq_root;
                            r_state <= ST_SQU;
                        end else begin
                            r_lenu <= sq_root;
                            r_step <= '0;
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (!r_wait) begin
                        r_nneg[r_step[2:0]] <= div_neg;
                        if (div_len == 32'd0) begin
                            r_n[r_step[2:0]] <= '0;
                            r_step <= r_step + 4'd1;
                            if (r_step == 4'd5) begin
                                r_step <= '0;
                                r_state <= ST_SCL;
                            end
                        end else begin
                            r_dv_start <= 1'b1;
                            r_wait <= 1'b1;
                        end
                    end else if (dv_done) begin
                        r_wait <= 1'b0;
                        r_n[r_step[2:0]] <= q_cap;
                        r_step <= r_step + 4'd1;
                        if (r_step == 4'd5) begin
                            r_step <= '0;
                            r_state <= ST_SCL;
                        end
                    end
                end
                ST_SCL: begin
                    r_prod <= mac_a * mac_b;
                    r_pneg <= 1'b0;
                    r_pstep <= 5'd16 + 5'(r_step);
                    r_pv <= (r_step != 4'd6);
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd6) begin
                        r_ci <= '0;
                        r_ax <= '0;
                        r_state <= ST_CRN;
                    end
                end
                ST_CRN: begin
                    r_cs[r_ci][r_ax] <= c_sat[31:0];
                    if (r_ax == 2'd2) begin
                        r_ax <= '0;
                        r_ci <= r_ci + 2'd1;
                        if (r_ci == 2'd3) begin
                            r_step <= '0;
                            r_state <= ST_UV;
                        end
                    end else begin
                        r_ax <= r_ax + 2'd1;
                    end
                end
                ST_UV: begin
                    if (!r_anim) begin
                        r_tu0 <= '0;
                        r_tu1 <= ONE_UV;
                        r_tv0 <= '0;
                        r_tv1 <= ONE_UV;
                        r_state <= r_emit ? ST_OUT : ST_IDLE;
                    end else if (!r_wait) begin
                        r_dv_start <= 1'b1;
                        r_wait <= 1'b1;
                    end else if (dv_done) begin
                        r_wait <= 1'b0;
                        r_step <= r_step + 4'd1;
                        case (r_step)
                            4'd0: begin
                                r_col0 <= dv_rem[4:0];
                                r_row0 <= dv_quot[4:0];
                            end
                            4'd1: r_tu0 <= e_cap;
                            4'd2: r_tu1 <= e_cap;
                            4'd3: r_tv0 <= e_cap;
                            default: begin
                                r_tv1 <= e_cap;
                                r_state <= r_emit ? ST_OUT : ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_OUT: begin
                    if (o_out.ready) begin
                        r_k <= r_k + 2'd1;
                        if (r_k == 2'd3) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    t_out_item out_d;

    always_comb begin
        out_d.corner_index = r_k;
        out_d.corner_x = r_cs[r_k][0];
        out_d.corner_y = r_cs[r_k][1];
        out_d.corner_z = r_cs[r_k][2];
        out_d.tex_u = r_k[0] ? r_tu1 : r_tu0;
        out_d.tex_v = r_k[1] ? r_tv0 : r_tv1;
        out_d.frame_number = r_frame[8:0];
        out_d.last_corner = (r_k == 2'd3);
    end

    assign o_out.valid = (r_state == ST_OUT);
    assign o_out.data = out_d;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("input taken while corners pending");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && r_k == 2'd3) |=> i_in.ready)
        else $error("not idle after last corner");

    a_frame_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame != '0)
        else $error("frame number is zero");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_sq_start && r_dv_start))
        else $error("root and divide started together");
`endif

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// testbench for billboard_sprite_quad_unit: directed and random ticks checked against
// a cycle-free predictor of corners, uvs and frame numbers
// depends on bsq_pkg, bsq_chan_if and the rtl of the unit
`timescale 1ns / 1ps

module tb;
    import bsq_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bsq_chan_if #(.t_data(t_in_item))  in_ch ();
    bsq_chan_if #(.t_data(t_out_item)) out_ch ();
    bsq_chan_if #(.t_data(t_cfg_wr))   cfg_ch ();

    billboard_sprite_quad_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    int unsigned half_w, height_sz, period_us, columns, rows_cfg;
    bit          anim_on, loop_on;
    bit          active;
    int unsigned frame_idx, time_acc;
    longint      corners [4][3];
    int unsigned uvs [4][2];

    t_out_item corner_queue [$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        no_gaps = 1'b0;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 1200;

    function automatic longint unsigned isqrt_u64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void unit_vec(input longint c [3], output longint n [3]);
        longint unsigned sum, len, m, q;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m = (c[i] < 0) ? -c[i] : c[i];
            sum += m * m;
        end
        len = isqrt_u64(sum);
        for (int i = 0; i < 3; i++) begin
            m = (c[i] < 0) ? -c[i] : c[i];
            q = 0;
            if (len != 0) begin
                q = (m << 30) / len;
                if (q > (64'd1 << 30)) q = 64'd1 << 30;
            end
            n[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic longint half_offset(input longint n, input int unsigned sz);
        longint unsigned m;
        m = (((n < 0) ? -n : n) * longint'(sz)) >> 31;
        return (n < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic int unsigned side_clamp(input int unsigned s);
        if (s == 0) return 1;
        return (s > 16) ? 16 : s;
    endfunction

    function automatic int unsigned uv_edge(input int unsigned k, input int unsigned n);
        int unsigned e;
        e = (k * 32768) / n;
        return (e > 32768) ? 32768 : e;
    endfunction

    function automatic void apply_cfg(input t_cfg_wr w);
        case (w.index)
            CFG_HALF_WIDTH:   half_w = w.value;
            CFG_HEIGHT:       height_sz = w.value;
            CFG_FRAME_PERIOD: period_us = w.value[19:0];
            CFG_COLUMNS:      columns = w.value[4:0];
            CFG_ROWS:         rows_cfg = w.value[4:0];
            CFG_ANIMATED:     anim_on = w.value[0];
            CFG_LOOP:         loop_on = w.value[0];
            default: ;
        endcase
    endfunction

    function automatic void predict_corners(input t_in_item it);
        int unsigned cols, rws, total, f0, c0, r0, u0, u1, v0, v1;
        longint d [3], u [3], ctr [3], r [3], rn [3], un [3], ro, uo;
        t_out_item o;
        cols = side_clamp(columns);
        rws = side_clamp(rows_cfg);
        total = cols * rws;
        if (it.start_req) begin
            active = 1'b1;
            frame_idx = 1;
            time_acc = 0;
        end
        if (!active) return;
        if (anim_on && !loop_on && frame_idx == total) active = 1'b0;
        if (it.camera_valid) begin
            d = '{it.dir_x, it.dir_y, it.dir_z};
            u = '{it.up_x, it.up_y, it.up_z};
            ctr = '{it.center_x, it.center_y, it.center_z};
            r[0] = u[1] * d[2] - u[2] * d[1];
            r[1] = u[2] * d[0] - u[0] * d[2];
            r[2] = u[0] * d[1] - u[1] * d[0];
            unit_vec(r, rn);
            unit_vec(u, un);
            for (int i = 0; i < 3; i++) begin
                ro = half_offset(rn[i], half_w);
                uo = half_offset(un[i], height_sz);
                corners[0][i] = sat32(ctr[i] - ro - uo);
                corners[1][i] = sat32(ctr[i] + ro - uo);
                corners[2][i] = sat32(ctr[i] - ro + uo);
                corners[3][i] = sat32(ctr[i] + ro + uo);
            end
        end
        if (anim_on) begin
            time_acc += it.time_delta_us;
            if (time_acc > period_us) begin
                frame_idx++;
                time_acc = 0;
            end
            if (frame_idx > total) begin
                frame_idx = 1;
                time_acc = 0;
            end
            if (it.camera_valid) begin
                f0 = frame_idx - 1;
                c0 = f0 % cols;
                r0 = f0 / cols;
                u0 = uv_edge(c0, cols);
                u1 = uv_edge(c0 + 1, cols);
                v0 = uv_edge(r0, rws);
                v1 = uv_edge(r0 + 1, rws);
                uvs = '{'{u0, v1}, '{u1, v1}, '{u0, v0}, '{u1, v0}};
            end
        end else if (it.camera_valid) begin
            uvs = '{'{0, 32768}, '{32768, 32768}, '{0, 0}, '{32768, 0}};
        end
        if (!active) return;
        for (int k = 0; k < 4; k++) begin
            o.corner_index = k;
            o.corner_x = corners[k][0][31:0];
            o.corner_y = corners[k][1][31:0];
            o.corner_z = corners[k][2][31:0];
            o.tex_u = uvs[k][0][15:0];
            o.tex_v = uvs[k][1][15:0];
            o.frame_number = frame_idx[8:0];
            o.last_corner = (k == 3);
            corner_queue.push_back(o);
        end
    endfunction

    function automatic int rand_gap();
        int p;
        if (no_gaps) return 0;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_tick(input t_in_item it);
        int gap;
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.data = it;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_corners(it);
        gap = rand_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (corner_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        t_cfg_wr w;
        w.index = idx;
        w.value = val;
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data = w;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_cfg(w);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic write_all(input int unsigned hw, input int unsigned ht,
                             input int unsigned per, input int unsigned cols,
                             input int unsigned rws, input bit an, input bit lp);
        write_reg(CFG_HALF_WIDTH, hw);
        write_reg(CFG_HEIGHT, ht);
        write_reg(CFG_FRAME_PERIOD, per);
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, rws);
        write_reg(CFG_ANIMATED, an);
        write_reg(CFG_LOOP, lp);
    endtask

    function automatic t_in_item make_tick(input bit st, input bit cam,
                                           input logic [19:0] dt,
                                           input int dx, input int dy, input int dz,
                                           input int ux, input int uy, input int uz,
                                           input int cx, input int cy, input int cz);
        t_in_item it;
        it.start_req = st;
        it.camera_valid = cam;
        it.time_delta_us = dt;
        it.dir_x = dx; it.dir_y = dy; it.dir_z = dz;
        it.up_x = ux;  it.up_y = uy;  it.up_z = uz;
        it.center_x = cx; it.center_y = cy; it.center_z = cz;
        return it;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        int p;
        p = $urandom_range(0, 9);
        if (p < 5) return $urandom();
        if (p < 8) return $signed($urandom_range(0, 32768)) - 16384;
        return (p == 8) ? 16'sh8000 : 16'sh7fff;
    endfunction

    function automatic logic signed [31:0] rand_center();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return $signed($urandom_range(0, 2000000)) - 1000000;
    endfunction

    function automatic t_in_item rand_tick();
        t_in_item it;
        it.start_req = active ? ($urandom_range(0, 14) == 0) : ($urandom_range(0, 3) != 0);
        it.camera_valid = ($urandom_range(0, 6) != 0);
        it.time_delta_us = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1000000)
                                                       : $urandom_range(0, 2 * period_us + 2);
        if (it.time_delta_us > 1000000) it.time_delta_us = 1000000;
        it.dir_x = rand_comp(); it.dir_y = rand_comp(); it.dir_z = rand_comp();
        it.up_x = rand_comp();  it.up_y = rand_comp();  it.up_z = rand_comp();
        case ($urandom_range(0, 11))
            0: {it.up_x, it.up_y, it.up_z} = '0;
            1: {it.up_x, it.up_y, it.up_z} = {it.dir_x, it.dir_y, it.dir_z};
            2: {it.dir_x, it.dir_y, it.dir_z} = '0;
            default: ;
        endcase
        it.center_x = rand_center(); it.center_y = rand_center(); it.center_z = rand_center();
        return it;
    endfunction

    task automatic run_random(input int n);
        repeat (n) send_tick(rand_tick());
        settle();
    endtask

    task automatic test_inactive_ignore();
        send_tick(make_tick(0, 1, 20'd100, 0, 0, 16384, 0, 16384, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 20'hfffff & 1000000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        settle();
    endtask

    task automatic test_static_geometry();
        // no camera yet: stored corners and uvs are still zero
        send_tick(make_tick(1, 0, 0, 0, 0, 0, 0, 0, 0, 5, 5, 5));
        send_tick(make_tick(0, 1, 0, 0, 0, 16384, 0, 16384, 0, 65536, -65536, 0));
        send_tick(make_tick(0, 1, 0, -32768, -32768, -32768, 32767, 32767, 32767,
                            32'h7fffffff, 32'h80000000, 1));
        send_tick(make_tick(0, 1, 0, 32767, -32768, 0, -32768, 32767, -1,
                            -1, 0, 32'h7fffffff));
        send_tick(make_tick(0, 1, 0, 100, 200, 300, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(0, 1, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 0, 1, 1, 1, 1, 1, 1, 9, 9, 9));
        settle();
        write_reg(CFG_HALF_WIDTH, 31'h7fffffff);
        write_reg(CFG_HEIGHT, 31'h7fffffff);
        send_tick(make_tick(0, 1, 0, 0, 0, -16384, 0, 16384, 0,
                            32'h7fff0000, 32'h80010000, 0));
        send_tick(make_tick(0, 1, 0, 32767, 32767, 32767, -32768, 32767, 0,
                            32'h80000000, 32'h7fffffff, 32'h80000000));
        settle();
        write_reg(CFG_HALF_WIDTH, 0);
        write_reg(CFG_HEIGHT, 0);
        send_tick(make_tick(0, 1, 0, 1, 2, 3, 3, 2, 1, 7, 8, 9));
        settle();
    endtask

    task automatic test_last_frame();
        write_all(131072, 65536, 0, 2, 1, 1, 0);
        send_tick(make_tick(1, 1, 20'd5, 0, 0, 16384, 0, 16384, 0, 0, 0, 0));
        send_tick(make_tick(0, 1, 20'd5, 0, 0, 16384, 0, 16384, 0, 0, 0, 0));
        send_tick(make_tick(0, 1, 20'd5, 0, 0, 16384, 0, 16384, 0, 0, 0, 0));
        send_tick(make_tick(1, 0, 20'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        settle();
    endtask

    task automatic test_frame_wrap();
        // shrinking the sheet leaves the frame past the new total
        write_all(65536, 65536, 10, 31, 31, 1, 1);
        send_tick(make_tick(1, 1, 20'd11, 0, 0, 16384, 0, 16384, 0, 0, 0, 0));
        repeat (3) send_tick(make_tick(0, 1, 20'd11, 16384, 0, 0, 0, 0, 16384, 0, 0, 0));
        settle();
        write_reg(CFG_COLUMNS, 0);
        write_reg(CFG_ROWS, 1);
        send_tick(make_tick(0, 1, 20'd0, 16384, 0, 0, 0, 0, 16384, 0, 0, 0));
        settle();
    endtask

    task automatic test_random_phases();
        write_all(131072, 131072, 50000, 4, 4, 1, 1);
        run_random(65);
        no_gaps = 1'b1;
        write_all(31'h7fffffff, 31'h12345, 0, 16, 16, 1, 1);
        run_random(60);
        no_gaps = 1'b0;
        write_all($urandom(), $urandom(), 1000000, 3, 5, 1, 0);
        run_random(65);
        write_all($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20), 200, 1, 1, 0, 0);
        run_random(60);
        write_all(0, 31'h7fffffff, 1, 17, 2, 1, 0);
        run_random(70);
        write_all($urandom(), $urandom(), $urandom_range(0, 1000000),
                  $urandom_range(0, 31), $urandom_range(0, 31), 1, $urandom_range(0, 1));
        run_random(65);
    endtask

    // receiver with random backpressure
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = (rand_gap() == 0);
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp;
        t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (corner_queue.size() == 0) begin
                $display("%0t unexpected corner transaction %p", $time, got);
                errors++;
            end else begin
                exp = corner_queue.pop_front();
                if (got.corner_index !== exp.corner_index) begin
                    $display("%0t corner_index exp %0d got %0d", $time,
                             exp.corner_index, got.corner_index);
                    errors++;
                end
                if (got.corner_x !== exp.corner_x) begin
                    $display("%0t corner_x exp %0d got %0d", $time, exp.corner_x, got.corner_x);
                    errors++;
                end
                if (got.corner_y !== exp.corner_y) begin
                    $display("%0t corner_y exp %0d got %0d", $time, exp.corner_y, got.corner_y);
                    errors++;
                end
                if (got.corner_z !== exp.corner_z) begin
                    $display("%0t corner_z exp %0d got %0d", $time, exp.corner_z, got.corner_z);
                    errors++;
                end
                if (got.tex_u !== exp.tex_u) begin
                    $display("%0t tex_u exp %0d got %0d", $time, exp.tex_u, got.tex_u);
                    errors++;
                end
                if (got.tex_v !== exp.tex_v) begin
                    $display("%0t tex_v exp %0d got %0d", $time, exp.tex_v, got.tex_v);
                    errors++;
                end
                if (got.frame_number !== exp.frame_number) begin
                    $display("%0t frame_number exp %0d got %0d", $time,
                             exp.frame_number, got.frame_number);
                    errors++;
                end
                if (got.last_corner !== exp.last_corner) begin
                    $display("%0t last_corner exp %0d got %0d", $time,
                             exp.last_corner, got.last_corner);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        half_w = 131072;
        height_sz = 131072;
        period_us = 50000;
        columns = 4;
        rows_cfg = 4;
        anim_on = 1'b0;
        loop_on = 1'b1;
        active = 1'b0;
        frame_idx = 1;
        time_acc = 0;
        corners = '{default: '{default: 0}};
        uvs = '{default: '{default: 0}};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_inactive_ignore();
        test_static_geometry();
        test_last_frame();
        test_frame_wrap();
        test_random_phases();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
